/* sv/assert_macros.svh */
// Assertion macros shared by the overlap checker RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define COC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define COC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define COC_ASSERT(label, clk, rst_n, prop, msg)
`define COC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/coc_pkg.sv */
// Shared types and fixed field widths for the ternary pattern overlap checker.
// No dependencies.
package coc_pkg;

    localparam int FIELD_W   = 32;   // width of the signature and mask ports
    localparam int ENTRIES_W = 7;    // width of the entries_held result field

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic shift;    // take the neighbour's entry
        logic clear;    // end of set: drop all entries
    } t_cell_ctrl;

endpackage

/* sv/coc_cell.sv */
// One table entry of the overlap checker: holds a ternary pattern, compares it
// with the incoming request and passes its entry on to the next cell.
// Depends on coc_pkg.
module coc_cell #(
    parameter int PATTERN_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  coc_pkg::t_cell_ctrl     i_ctrl,
    input  logic [PATTERN_BITS-1:0] i_prev_sig,
    input  logic [PATTERN_BITS-1:0] i_prev_mask,
    input  logic                    i_prev_valid,
    input  logic [PATTERN_BITS-1:0] i_query_sig,
    input  logic [PATTERN_BITS-1:0] i_query_mask,
    output logic [PATTERN_BITS-1:0] o_sig,
    output logic [PATTERN_BITS-1:0] o_mask,
    output logic                    o_valid,
    output logic                    o_hit
);

    logic [PATTERN_BITS-1:0] r_sig;
    logic [PATTERN_BITS-1:0] r_mask;
    logic                    r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            priority if (i_ctrl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctrl.shift) begin
                r_valid <= i_prev_valid;
            end else begin
                r_valid <= r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_sig  <= i_prev_sig;
            r_mask <= i_prev_mask;
        end
    end

    // overlap: signatures agree wherever both masks care
    assign o_hit   = r_valid & ~|((i_query_sig ^ r_sig) & i_query_mask & r_mask);
    assign o_sig   = r_sig;
    assign o_mask  = r_mask;
    assign o_valid = r_valid;

endmodule

/* sv/cube_overlap_check.sv */
// Top level of the ternary pattern overlap checker: a shifting row of
// compare cells, a hit register and a result register.
// Depends on coc_pkg, coc_cell and assert_macros.svh.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | into      | i_in_valid / o_in_ready     | pattern_signature, pattern_mask, last
//  out     | out of    | o_out_valid / i_out_ready   | overlap, entries, overflow, set_done
//
// One request per cycle while o_in_ready is high; the cells compare in the accept
// cycle and the hit vector is registered at the accept edge; the OR with the sticky
// flag is registered in the result register when the hit stage advances, which an
// output stall can hold back.
// Every cell compares in the accept cycle, so throughput is set by output back-pressure.
// Synchronous active-low reset empties the table and clears both flags.
// A stalled output holds one result and one request in flight; input
// ready drops only when both are occupied.

`include "assert_macros.svh"

module cube_overlap_check #(
    parameter int MAX_PATTERNS = 64,
    parameter int PATTERN_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [coc_pkg::FIELD_W-1:0]       i_pattern_signature,
    input  logic [coc_pkg::FIELD_W-1:0]       i_pattern_mask,
    input  logic                              i_last_in_set,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_overlap_found,
    output logic [coc_pkg::ENTRIES_W-1:0]     o_entries_held,
    output logic                              o_table_overflow,
    output logic                              o_set_done
);

    localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
    localparam int USE_W  = (PATTERN_BITS < coc_pkg::FIELD_W) ? PATTERN_BITS
                                                              : coc_pkg::FIELD_W;
    localparam int HELD_W = coc_pkg::ENTRIES_W;
    localparam int WIDE_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;

    logic                    w_acc_in;
    logic                    w_full;
    logic                    w_a_adv;
    logic [PATTERN_BITS-1:0] w_q_sig;
    logic [PATTERN_BITS-1:0] w_q_mask;
    coc_pkg::t_cell_ctrl     w_ctrl;

    logic [PATTERN_BITS-1:0] w_sig  [MAX_PATTERNS];
    logic [PATTERN_BITS-1:0] w_mask [MAX_PATTERNS];
    logic [MAX_PATTERNS-1:0] w_vld;
    logic [MAX_PATTERNS-1:0] w_hit;

    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf_sticky;
    logic                    r_ovl_sticky;

    logic                    r_a_valid;
    logic [MAX_PATTERNS-1:0] r_a_hit;
    logic                    r_a_last;
    logic [CNT_W-1:0]        r_a_cnt;
    logic                    r_a_ovf;

    logic                    r_out_valid;
    logic                    r_out_ovl;
    logic [HELD_W-1:0]       r_out_held;
    logic                    r_out_ovf;
    logic                    r_out_last;

    logic                    w_ovl;
    logic [WIDE_W-1:0]       w_cnt_wide;

    assign w_acc_in = i_in_valid & o_in_ready;
    assign w_full   = (r_count == CNT_W'(MAX_PATTERNS));
    assign w_a_adv  = r_a_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_a_valid | w_a_adv;

    // bits above PATTERN_BITS are dropped, missing ones read as zero
    assign w_q_sig  = PATTERN_BITS'(i_pattern_signature[USE_W-1:0]);
    assign w_q_mask = PATTERN_BITS'(i_pattern_mask[USE_W-1:0]);

    assign w_ctrl.shift = w_acc_in & ~w_full;
    assign w_ctrl.clear = w_acc_in & i_last_in_set;

    // cell 0 takes the new pattern; each later cell takes its neighbour's
    for (genvar k = 0; k < MAX_PATTERNS; k++) begin : g_cell
        if (k == 0) begin : g_head
            coc_cell #(
                .PATTERN_BITS (PATTERN_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_prev_sig   (w_q_sig),
                .i_prev_mask  (w_q_mask),
                .i_prev_valid (1'b1),
                .i_query_sig  (w_q_sig),
                .i_query_mask (w_q_mask),
                .o_sig        (w_sig[k]),
                .o_mask       (w_mask[k]),
                .o_valid      (w_vld[k]),
                .o_hit        (w_hit[k])
            );
        end else begin : g_body
            coc_cell #(
                .PATTERN_BITS (PATTERN_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_prev_sig   (w_sig[k-1]),
                .i_prev_mask  (w_mask[k-1]),
                .i_prev_valid (w_vld[k-1]),
                .i_query_sig  (w_q_sig),
                .i_query_mask (w_q_mask),
                .o_sig        (w_sig[k]),
                .o_mask       (w_mask[k]),
                .o_valid      (w_vld[k]),
                .o_hit        (w_hit[k])
            );
        end
    end

    // set bookkeeping at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ovf_sticky <= 1'b0;
        end else if (w_acc_in) begin
            if (i_last_in_set) begin
                r_count      <= '0;
                r_ovf_sticky <= 1'b0;
            end else begin
                r_count      <= w_full ? r_count : r_count + CNT_W'(1);
                r_ovf_sticky <= r_ovf_sticky | w_full;
            end
        end
    end

    // hit register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            priority if (w_acc_in) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end else begin
                r_a_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_a_hit  <= w_hit;
            r_a_last <= i_last_in_set;
            r_a_cnt  <= w_full ? r_count : r_count + CNT_W'(1);
            r_a_ovf  <= r_ovf_sticky | w_full;
        end
    end

    // overlap flag is folded in request order as the hit stage drains
    assign w_ovl      = r_ovl_sticky | (|r_a_hit);
    assign w_cnt_wide = WIDE_W'(r_a_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl_sticky <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_a_adv) begin
                r_ovl_sticky <= r_a_last ? 1'b0 : w_ovl;
            end
            priority if (w_a_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_out_ovl  <= w_ovl;
            r_out_held <= w_cnt_wide[HELD_W-1:0];
            r_out_ovf  <= r_a_ovf;
            r_out_last <= r_a_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_overlap_found  = r_out_ovl;
    assign o_entries_held   = r_out_held;
    assign o_table_overflow = r_out_ovf;
    assign o_set_done       = r_out_last;

    `COC_ASSERT(a_count_in_range, i_clk, i_rst_n,
        r_count <= CNT_W'(MAX_PATTERNS), "entry count beyond table size")
    `COC_ASSERT(a_valid_matches_count, i_clk, i_rst_n,
        $countones(w_vld) == int'(r_count), "cell valid bits disagree with entry count")
    `COC_ASSERT(a_last_clears_set, i_clk, i_rst_n,
        (w_acc_in && i_last_in_set) |=> (r_count == '0 && !r_ovf_sticky && w_vld == '0),
        "set not cleared after last request")
    `COC_ASSERT(a_ovf_only_when_full, i_clk, i_rst_n,
        (w_acc_in && !r_ovf_sticky && !w_full) |=> (r_a_ovf == 1'b0),
        "overflow raised with room in the table")

endmodule
